// ===== src/aavr_pkg.sv =====
// ----------------------------------------------------------------------------
// aavr_pkg: shared types and constants of the axis-angle rotation block
// Holds the payload structs that travel along the cell chains, the Q2.30
// constants, the CORDIC arctangent table and the rounding helper.
// ----------------------------------------------------------------------------
package aavr_pkg;

  // Default parameter values
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 18;

  // Datapath widths
  localparam int unsigned CW           = 34;  // CORDIC x, y, z (Q2.30 plus headroom)
  localparam int unsigned SQRT_BITS    = 32;  // root bits of the squared axis length
  localparam int unsigned DIV_BITS     = 31;  // quotient bits of the unit axis
  localparam int unsigned ATAN_ENTRIES = 30;

  // Q2.30 constants
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam longint               PI_Q30_L    = 64'sd3373259426;

  // Fields that ride along every cell
  typedef struct packed {
    logic signed [31:0]   vx;
    logic signed [31:0]   vy;
    logic signed [31:0]   vz;
    logic signed [31:0]   vw;
    logic [2:0]           neg;
    logic                 zero;
    logic                 flip;
    logic signed [CW-1:0] z0;
  } carry_t;

  // Square root chain payload
  typedef struct packed {
    carry_t         cry;
    logic [2:0][31:0] c;
    logic [63:0]    rem;
    logic [31:0]    root;
  } sqrt_t;

  // Division chain payload
  typedef struct packed {
    carry_t                   cry;
    logic [31:0]              len;
    logic [2:0][63:0]         rem;
    logic [2:0][DIV_BITS-1:0] q;
  } div_t;

  // CORDIC chain payload
  typedef struct packed {
    carry_t               cry;
    logic [2:0][31:0]     k;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // arctan(2^-i) in Q2.30, truncated
  function automatic logic [31:0] atan_q30(input int unsigned idx);
    case (idx)
      0:  return 32'd843314856;
      1:  return 32'd497837829;
      2:  return 32'd263043836;
      3:  return 32'd133525158;
      4:  return 32'd67021686;
      5:  return 32'd33543515;
      6:  return 32'd16775850;
      7:  return 32'd8388437;
      8:  return 32'd4194282;
      9:  return 32'd2097149;
      10: return 32'd1048575;
      11: return 32'd524287;
      12: return 32'd262143;
      13: return 32'd131071;
      14: return 32'd65535;
      15: return 32'd32767;
      16: return 32'd16383;
      17: return 32'd8191;
      18: return 32'd4095;
      19: return 32'd2047;
      20: return 32'd1023;
      21: return 32'd511;
      22: return 32'd255;
      23: return 32'd127;
      24: return 32'd63;
      25: return 32'd31;
      26: return 32'd15;
      27: return 32'd8;
      28: return 32'd4;
      29: return 32'd2;
      default: return 32'd0;
    endcase
  endfunction

  // Arithmetic shift right by 30 with round-half-up
  function automatic logic signed [71:0] rnd30(input logic signed [71:0] v);
    return (v + 72'sd536870912) >>> 30;
  endfunction

endpackage

// ===== src/aavr_front.sv =====
// ----------------------------------------------------------------------------
// aavr_front: input register and axis preparation
// Captures the transaction, scales the axis so its largest magnitude lies in
// [2^30, 2^31], squares and sums it, and prepares the CORDIC start angle.
// ----------------------------------------------------------------------------
module aavr_front #(
  parameter int unsigned FRAC_BITS = aavr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  vec_x_i,
  input  logic signed [31:0]  vec_y_i,
  input  logic signed [31:0]  vec_z_i,
  input  logic signed [31:0]  vec_w_i,
  input  logic signed [31:0]  axis_x_i,
  input  logic signed [31:0]  axis_y_i,
  input  logic signed [31:0]  axis_z_i,
  input  logic signed [18:0]  angle_i,
  output logic                vld_o,
  output aavr_pkg::sqrt_t     dat_o,
  input  logic                rdy_i
);

  localparam int unsigned CW = aavr_pkg::CW;
  localparam longint PiQfL = (aavr_pkg::PI_Q30_L + (longint'(1) << (29 - FRAC_BITS)))
                             >>> (30 - FRAC_BITS);
  localparam logic signed [CW-1:0] PiQf = CW'(PiQfL);

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vw;
    logic [2:0][31:0]   ax;
    logic signed [18:0] ang;
  } raw_t;

  logic [3:0] vld_q;
  logic [3:0] rdy;
  logic [3:0] vin;
  logic [3:0] load;

  raw_t                   s0_q;
  aavr_pkg::carry_t       s1_cry_q, s2_cry_q, s1_cry_d;
  logic [2:0][31:0]       s1_c_q, s2_c_q, s1_c_d;
  logic [2:0][63:0]       s2_sq_q;
  aavr_pkg::sqrt_t        s3_q;

  logic [2:0][31:0]       mag;
  logic [31:0]            mx;
  logic [4:0]             sh;
  logic signed [CW-1:0]   ang_w, ang_c, zs;

  // Handshake chain: a stage loads when it is empty or its successor moves
  assign vin  = {vld_q[2:0], in_valid_i};
  assign rdy[3] = !vld_q[3] || rdy_i;
  assign rdy[2] = !vld_q[2] || rdy[3];
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];
  assign load = rdy & vin;
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < 4; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vin[s];
        end
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s0_q.vx  <= vec_x_i;
      s0_q.vy  <= vec_y_i;
      s0_q.vz  <= vec_z_i;
      s0_q.vw  <= vec_w_i;
      s0_q.ax  <= {axis_z_i, axis_y_i, axis_x_i};
      s0_q.ang <= angle_i;
    end
  end

  // Scale the axis magnitudes and fold the angle into the CORDIC range
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = s0_q.ax[j][31] ? (~s0_q.ax[j] + 32'd1) : s0_q.ax[j];
    end
    mx = mag[0];
    if (mag[1] > mx) begin
      mx = mag[1];
    end
    if (mag[2] > mx) begin
      mx = mag[2];
    end
    sh = '0;
    for (int p = 0; p < 31; p++) begin
      if (mx[p]) begin
        sh = 5'(30 - p);
      end
    end
    if (mx[31]) begin
      sh = '0;
    end
    for (int j = 0; j < 3; j++) begin
      s1_c_d[j] = mag[j] << sh;
    end

    ang_w = CW'(s0_q.ang);
    if (ang_w > PiQf) begin
      ang_c = PiQf;
    end else if (ang_w < -PiQf) begin
      ang_c = -PiQf;
    end else begin
      ang_c = ang_w;
    end
    zs = ang_c <<< (30 - FRAC_BITS);

    s1_cry_d.vx   = s0_q.vx;
    s1_cry_d.vy   = s0_q.vy;
    s1_cry_d.vz   = s0_q.vz;
    s1_cry_d.vw   = s0_q.vw;
    s1_cry_d.neg  = {s0_q.ax[2][31], s0_q.ax[1][31], s0_q.ax[0][31]};
    s1_cry_d.zero = (mx == '0);
    if (zs > aavr_pkg::HALF_PI_Q30) begin
      s1_cry_d.z0   = zs - aavr_pkg::PI_Q30;
      s1_cry_d.flip = 1'b1;
    end else if (zs < -aavr_pkg::HALF_PI_Q30) begin
      s1_cry_d.z0   = zs + aavr_pkg::PI_Q30;
      s1_cry_d.flip = 1'b1;
    end else begin
      s1_cry_d.z0   = zs;
      s1_cry_d.flip = 1'b0;
    end
  end

  // Register the scaled axis, then square, then sum
  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      s1_cry_q <= s1_cry_d;
      s1_c_q   <= s1_c_d;
    end
    if (load[2]) begin
      s2_cry_q <= s1_cry_q;
      s2_c_q   <= s1_c_q;
      for (int j = 0; j < 3; j++) begin
        s2_sq_q[j] <= 64'(s1_c_q[j]) * 64'(s1_c_q[j]);
      end
    end
    if (load[3]) begin
      s3_q.cry  <= s2_cry_q;
      s3_q.c    <= s2_c_q;
      s3_q.rem  <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      s3_q.root <= '0;
    end
  end

  assign vld_o = vld_q[3];
  assign dat_o = s3_q;

endmodule

// ===== src/aavr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// aavr_sqrt_cell: one bit of the pipelined integer square root
// Tries to set one root bit against the remainder and hands the partial root
// and remainder to the next cell.
// ----------------------------------------------------------------------------
module aavr_sqrt_cell #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  aavr_pkg::sqrt_t dat_i,
  output logic            rdy_o,
  output logic            vld_o,
  output aavr_pkg::sqrt_t dat_o,
  input  logic            rdy_i
);

  logic            vld_q;
  aavr_pkg::sqrt_t dat_q, dat_d;
  logic [65:0]     trial;

  assign rdy_o = !vld_q || rdy_i;

  // Subtract (2*root + 2^b) * 2^b when it fits
  always_comb begin
    trial = (66'(dat_i.root) << (BIT_POS + 1)) + (66'(1) << (2 * BIT_POS));
    dat_d = dat_i;
    if ({2'b00, dat_i.rem} >= trial) begin
      dat_d.rem           = dat_i.rem - trial[63:0];
      dat_d.root[BIT_POS] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

// ===== src/aavr_div_cell.sv =====
// ----------------------------------------------------------------------------
// aavr_div_cell: one quotient bit of the three axis divisions
// Restoring division step shared by the x, y and z axis components, all
// divided by the same axis length.
// ----------------------------------------------------------------------------
module aavr_div_cell #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  aavr_pkg::div_t dat_i,
  output logic           rdy_o,
  output logic           vld_o,
  output aavr_pkg::div_t dat_o,
  input  logic           rdy_i
);

  logic           vld_q;
  aavr_pkg::div_t dat_q, dat_d;
  logic [63:0]    dsr;

  assign rdy_o = !vld_q || rdy_i;

  // Subtract the shifted divisor from each remainder where it fits
  always_comb begin
    dsr   = 64'(dat_i.len) << BIT_POS;
    dat_d = dat_i;
    for (int j = 0; j < 3; j++) begin
      if (dat_i.rem[j] >= dsr) begin
        dat_d.rem[j]        = dat_i.rem[j] - dsr;
        dat_d.q[j][BIT_POS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

// ===== src/aavr_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// aavr_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates (x, y) by arctan(2^-IDX) in the direction of the residual angle.
// ----------------------------------------------------------------------------
module aavr_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  aavr_pkg::cordic_t dat_i,
  output logic              rdy_o,
  output logic              vld_o,
  output aavr_pkg::cordic_t dat_o,
  input  logic              rdy_i
);

  localparam int unsigned CW = aavr_pkg::CW;
  localparam logic signed [CW-1:0] Atan = $signed({2'b00, aavr_pkg::atan_q30(IDX)});

  logic                 vld_q;
  aavr_pkg::cordic_t    dat_q, dat_d;
  logic signed [CW-1:0] xs, ys;

  assign rdy_o = !vld_q || rdy_i;

  // Rotate toward zero residual angle
  always_comb begin
    xs    = dat_i.x >>> IDX;
    ys    = dat_i.y >>> IDX;
    dat_d = dat_i;
    if (!dat_i.z[CW-1]) begin
      dat_d.x = dat_i.x - ys;
      dat_d.y = dat_i.y + xs;
      dat_d.z = dat_i.z - Atan;
    end else begin
      dat_d.x = dat_i.x + ys;
      dat_d.y = dat_i.y - xs;
      dat_d.z = dat_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

// ===== src/aavr_back.sv =====
// ----------------------------------------------------------------------------
// aavr_back: Rodrigues combination and output register
// Seven stages: sine and cosine clamp, cross, dot and cosine products,
// rounding, second products, rounding, axis products, then the final sum,
// saturation and zero-axis bypass into the output register.
// ----------------------------------------------------------------------------
module aavr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  aavr_pkg::cordic_t dat_i,
  output logic              rdy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [31:0] rot_x_o,
  output logic signed [31:0] rot_y_o,
  output logic signed [31:0] rot_z_o,
  output logic signed [31:0] rot_w_o,
  output logic              axis_zero_o
);

  localparam int unsigned CW = aavr_pkg::CW;
  localparam int unsigned NumSt = 7;
  localparam logic signed [39:0] SatHi = 40'sd2147483647;
  localparam logic signed [39:0] SatLo = -40'sd2147483648;

  logic [NumSt-1:0] vld_q, rdy, vin, load;

  aavr_pkg::carry_t   cry_q [NumSt-1];
  logic signed [31:0] k_q   [5][3];

  // Stage 0
  logic signed [CW-1:0] xf, yf;
  logic signed [31:0]   cs_q, sn0_q;
  logic signed [32:0]   omc0_q;
  // Stage 1
  logic signed [63:0]   pcr_q [6];
  logic signed [63:0]   pdot_q [3];
  logic signed [63:0]   pt1_q [3];
  logic signed [31:0]   sn1_q;
  logic signed [32:0]   omc1_q;
  // Stage 2
  logic signed [33:0]   cr_q [3];
  logic signed [33:0]   dot_q;
  logic signed [31:0]   sn2_q;
  logic signed [32:0]   omc2_q;
  logic signed [35:0]   t1_q [4][3];
  // Stage 3
  logic signed [71:0]   ps_q;
  logic signed [71:0]   pc_q [3];
  // Stage 4
  logic signed [35:0]   sc_q;
  logic signed [35:0]   t2_q [2][3];
  // Stage 5
  logic signed [71:0]   pk_q [3];
  // Stage 6
  logic signed [35:0]   t3 [3];
  logic signed [39:0]   sum [3];
  logic signed [31:0]   sat [3];
  logic signed [31:0]   rot_q [4];
  logic                 zero_q;

  // Handshake chain through the stages
  assign vin = {vld_q[NumSt-2:0], vld_i};
  always_comb begin
    rdy[NumSt-1] = !vld_q[NumSt-1] || !out_stall_i;
    for (int s = NumSt - 2; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end
  assign load  = rdy & vin;
  assign rdy_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int s = 0; s < NumSt; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vin[s];
        end
      end
    end
  end

  // Advance the pass-through fields and the unit axis
  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      cry_q[0] <= dat_i.cry;
      for (int j = 0; j < 3; j++) begin
        k_q[0][j] <= $signed(dat_i.k[j]);
      end
    end
    for (int s = 1; s < NumSt - 1; s++) begin
      if (load[s]) begin
        cry_q[s] <= cry_q[s-1];
      end
    end
    for (int s = 1; s < 5; s++) begin
      if (load[s]) begin
        k_q[s] <= k_q[s-1];
      end
    end
  end

  // Stage 0: undo the half-turn fold and clamp sine and cosine
  always_comb begin
    xf = dat_i.cry.flip ? -dat_i.x : dat_i.x;
    yf = dat_i.cry.flip ? -dat_i.y : dat_i.y;
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      if (xf > aavr_pkg::ONE_Q30) begin
        cs_q   <= 32'(aavr_pkg::ONE_Q30);
        omc0_q <= '0;
      end else if (xf < -aavr_pkg::ONE_Q30) begin
        cs_q   <= 32'(-aavr_pkg::ONE_Q30);
        omc0_q <= 33'(aavr_pkg::ONE_Q30 <<< 1);
      end else begin
        cs_q   <= 32'(xf);
        omc0_q <= 33'(aavr_pkg::ONE_Q30 - xf);
      end
      if (yf > aavr_pkg::ONE_Q30) begin
        sn0_q <= 32'(aavr_pkg::ONE_Q30);
      end else if (yf < -aavr_pkg::ONE_Q30) begin
        sn0_q <= 32'(-aavr_pkg::ONE_Q30);
      end else begin
        sn0_q <= 32'(yf);
      end
    end
  end

  // Stage 1: cross, dot and cosine products
  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      pcr_q[0]  <= 64'(k_q[0][1]) * 64'(cry_q[0].vz);
      pcr_q[1]  <= 64'(k_q[0][2]) * 64'(cry_q[0].vy);
      pcr_q[2]  <= 64'(k_q[0][2]) * 64'(cry_q[0].vx);
      pcr_q[3]  <= 64'(k_q[0][0]) * 64'(cry_q[0].vz);
      pcr_q[4]  <= 64'(k_q[0][0]) * 64'(cry_q[0].vy);
      pcr_q[5]  <= 64'(k_q[0][1]) * 64'(cry_q[0].vx);
      pdot_q[0] <= 64'(k_q[0][0]) * 64'(cry_q[0].vx);
      pdot_q[1] <= 64'(k_q[0][1]) * 64'(cry_q[0].vy);
      pdot_q[2] <= 64'(k_q[0][2]) * 64'(cry_q[0].vz);
      pt1_q[0]  <= 64'(cry_q[0].vx) * 64'(cs_q);
      pt1_q[1]  <= 64'(cry_q[0].vy) * 64'(cs_q);
      pt1_q[2]  <= 64'(cry_q[0].vz) * 64'(cs_q);
      sn1_q     <= sn0_q;
      omc1_q    <= omc0_q;
    end
  end

  // Stage 2: round cross, dot and the cosine term
  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      for (int j = 0; j < 3; j++) begin
        cr_q[j]    <= 34'(aavr_pkg::rnd30(72'(pcr_q[2*j]) - 72'(pcr_q[2*j+1])));
        t1_q[0][j] <= 36'(aavr_pkg::rnd30(72'(pt1_q[j])));
      end
      dot_q  <= 34'(aavr_pkg::rnd30(72'(pdot_q[0]) + 72'(pdot_q[1]) + 72'(pdot_q[2])));
      sn2_q  <= sn1_q;
      omc2_q <= omc1_q;
    end
  end

  // Stage 3: dot times one minus cosine, cross times sine
  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      ps_q <= 72'(dot_q) * 72'(omc2_q);
      for (int j = 0; j < 3; j++) begin
        pc_q[j] <= 72'(cr_q[j]) * 72'(sn2_q);
      end
      t1_q[1] <= t1_q[0];
    end
  end

  // Stage 4: round the scale and the sine term
  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      sc_q <= 36'(aavr_pkg::rnd30(ps_q));
      for (int j = 0; j < 3; j++) begin
        t2_q[0][j] <= 36'(aavr_pkg::rnd30(pc_q[j]));
      end
      t1_q[2] <= t1_q[1];
    end
  end

  // Stage 5: axis times scale
  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      for (int j = 0; j < 3; j++) begin
        pk_q[j] <= 72'(k_q[4][j]) * 72'(sc_q);
      end
      t1_q[3] <= t1_q[2];
      t2_q[1] <= t2_q[0];
    end
  end

  // Stage 6: sum the three terms and saturate
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t3[j]  = 36'(aavr_pkg::rnd30(pk_q[j]));
      sum[j] = 40'(t1_q[3][j]) + 40'(t2_q[1][j]) + 40'(t3[j]);
      if (sum[j] > SatHi) begin
        sat[j] = 32'sh7fffffff;
      end else if (sum[j] < SatLo) begin
        sat[j] = 32'sh80000000;
      end else begin
        sat[j] = sum[j][31:0];
      end
    end
  end

  // Drop the rotation for a zero axis and hold the result
  always_ff @(posedge clk_i) begin
    if (load[6]) begin
      zero_q   <= cry_q[5].zero;
      rot_q[3] <= cry_q[5].vw;
      if (cry_q[5].zero) begin
        rot_q[0] <= cry_q[5].vx;
        rot_q[1] <= cry_q[5].vy;
        rot_q[2] <= cry_q[5].vz;
      end else begin
        rot_q[0] <= sat[0];
        rot_q[1] <= sat[1];
        rot_q[2] <= sat[2];
      end
    end
  end

  assign out_valid_o = vld_q[NumSt-1];
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign rot_w_o     = rot_q[3];
  assign axis_zero_o = zero_q;

endmodule

// ===== src/axis_angle_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation: Rodrigues rotation of a vector about an axis
// Fully pipelined: takes one transaction per clock while the result channel is
// not stalled and returns one result per transaction, in order. It is built of
// 4 front stages, a 32-cell square-root chain for the axis length, a 31-cell
// division chain for the unit axis, one cell per CORDIC step, and 7 stages of
// products, rounding and saturation. Each cell holds one register stage and
// stalls only when it is full and its successor is stalled, so a waiting
// result does not block new transactions until the whole pipeline has filled.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation #(
  parameter int unsigned FRAC_BITS    = aavr_pkg::FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] vec_w_i,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  input  logic signed [18:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] rot_x_o,
  output logic signed [31:0] rot_y_o,
  output logic signed [31:0] rot_z_o,
  output logic signed [31:0] rot_w_o,
  output logic               axis_zero_o
);

  localparam int unsigned SqrtBits = aavr_pkg::SQRT_BITS;
  localparam int unsigned DivBits  = aavr_pkg::DIV_BITS;

  logic              sq_vld [SqrtBits+1];
  logic              sq_rdy [SqrtBits+1];
  aavr_pkg::sqrt_t   sq_dat [SqrtBits+1];
  logic              dv_vld [DivBits+1];
  logic              dv_rdy [DivBits+1];
  aavr_pkg::div_t    dv_dat [DivBits+1];
  logic              cd_vld [CORDIC_STEPS+1];
  logic              cd_rdy [CORDIC_STEPS+1];
  aavr_pkg::cordic_t cd_dat [CORDIC_STEPS+1];

  // Capture and axis preparation
  aavr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .vec_w_i    (vec_w_i),
    .axis_x_i   (axis_x_i),
    .axis_y_i   (axis_y_i),
    .axis_z_i   (axis_z_i),
    .angle_i    (angle_i),
    .vld_o      (sq_vld[0]),
    .dat_o      (sq_dat[0]),
    .rdy_i      (sq_rdy[0])
  );

  // Square root of the squared axis length, most significant bit first
  for (genvar g = 0; g < SqrtBits; g++) begin : g_sqrt
    aavr_sqrt_cell #(
      .BIT_POS (SqrtBits - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (sq_vld[g]),
      .dat_i  (sq_dat[g]),
      .rdy_o  (sq_rdy[g]),
      .vld_o  (sq_vld[g+1]),
      .dat_o  (sq_dat[g+1]),
      .rdy_i  (sq_rdy[g+1])
    );
  end

  // Form the rounded dividends from the scaled axis and the length
  always_comb begin
    dv_dat[0].cry = sq_dat[SqrtBits].cry;
    dv_dat[0].len = sq_dat[SqrtBits].root;
    for (int j = 0; j < 3; j++) begin
      dv_dat[0].rem[j] = (64'(sq_dat[SqrtBits].c[j]) << 30)
                       + 64'(sq_dat[SqrtBits].root >> 1);
    end
    dv_dat[0].q = '0;
  end
  assign dv_vld[0]        = sq_vld[SqrtBits];
  assign sq_rdy[SqrtBits] = dv_rdy[0];

  // Unit axis by restoring division
  for (genvar g = 0; g < DivBits; g++) begin : g_div
    aavr_div_cell #(
      .BIT_POS (DivBits - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (dv_vld[g]),
      .dat_i  (dv_dat[g]),
      .rdy_o  (dv_rdy[g]),
      .vld_o  (dv_vld[g+1]),
      .dat_o  (dv_dat[g+1]),
      .rdy_i  (dv_rdy[g+1])
    );
  end

  // Apply the axis signs and seed the CORDIC
  always_comb begin
    cd_dat[0].cry = dv_dat[DivBits].cry;
    for (int j = 0; j < 3; j++) begin
      if (dv_dat[DivBits].cry.neg[j]) begin
        cd_dat[0].k[j] = -{1'b0, dv_dat[DivBits].q[j]};
      end else begin
        cd_dat[0].k[j] = {1'b0, dv_dat[DivBits].q[j]};
      end
    end
    cd_dat[0].x = aavr_pkg::GAIN_Q30;
    cd_dat[0].y = '0;
    cd_dat[0].z = dv_dat[DivBits].cry.z0;
  end
  assign cd_vld[0]       = dv_vld[DivBits];
  assign dv_rdy[DivBits] = cd_rdy[0];

  // Sine and cosine
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    aavr_cordic_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (cd_vld[g]),
      .dat_i  (cd_dat[g]),
      .rdy_o  (cd_rdy[g]),
      .vld_o  (cd_vld[g+1]),
      .dat_o  (cd_dat[g+1]),
      .rdy_i  (cd_rdy[g+1])
    );
  end

  // Rodrigues combination and output register
  aavr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (cd_vld[CORDIC_STEPS]),
    .dat_i       (cd_dat[CORDIC_STEPS]),
    .rdy_o       (cd_rdy[CORDIC_STEPS]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o),
    .rot_z_o     (rot_z_o),
    .rot_w_o     (rot_w_o),
    .axis_zero_o (axis_zero_o)
  );

endmodule

// ===== src/aavr_checker.sv =====
// ----------------------------------------------------------------------------
// aavr_port_checker: port-level checks of the rotation block
// Watches the handshakes on the top-level ports and is bound to the top.
// ----------------------------------------------------------------------------
module aavr_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic signed [31:0] vec_x_i,
  input logic signed [31:0] vec_y_i,
  input logic signed [31:0] vec_z_i,
  input logic signed [31:0] vec_w_i,
  input logic signed [31:0] axis_x_i,
  input logic signed [31:0] axis_y_i,
  input logic signed [31:0] axis_z_i,
  input logic signed [18:0] angle_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] rot_x_o,
  input logic signed [31:0] rot_y_o,
  input logic signed [31:0] rot_z_o,
  input logic signed [31:0] rot_w_o,
  input logic               axis_zero_o
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  // Keep a stalled result stable
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({rot_x_o, rot_y_o, rot_z_o, rot_w_o, axis_zero_o}))
    else $error("stalled result changed");

  // Stall the input only when the output is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Empty pipeline during reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty in reset");

endmodule

bind axis_angle_vector_rotation aavr_port_checker u_checker (.*);

// ===== tb/aavr_checker.sv =====
// ----------------------------------------------------------------------------
// aavr_checker: scoreboard for the axis-angle rotation block
// Watches both channels. Computes the expected rotation for each accepted
// input transaction and compares each accepted result, field by field, with
// the oldest expectation.
// ----------------------------------------------------------------------------
module aavr_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] vec_w_i,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  input  logic signed [18:0] angle_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  input  logic signed [31:0] rot_w_i,
  input  logic               axis_zero_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam int unsigned FRAC  = aavr_pkg::FRAC_BITS_DEF;
  localparam int unsigned STEPS = aavr_pkg::CORDIC_STEPS_DEF;
  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint HPI_Q30  = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint PI_QF    = (PI_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               zero;
  } rotation_t;

  rotation_t rot_expected[$];

  // arctan(2^-i) in Q2.30, truncated
  longint arctan_q30 [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2};

  function automatic longint round30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rotation-mode CORDIC with quadrant fold
  function automatic void cordic_sin_cos(input logic signed [18:0] ang, output longint sn,
                                         output longint cs);
    longint x, y, z, nx;
    bit flip;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    z = clip(longint'(ang), -PI_QF, PI_QF) * (64'sd1 <<< (30 - FRAC));
    if (z > HPI_Q30) begin
      z = z - PI_Q30;
      flip = 1;
    end else if (z < -HPI_Q30) begin
      z = z + PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < STEPS && i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_q30[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = clip(x, -ONE_Q30, ONE_Q30);
    sn = clip(y, -ONE_Q30, ONE_Q30);
  endfunction

  function automatic rotation_t rotate_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                                             logic signed [31:0] vz, logic signed [31:0] vw,
                                             logic signed [31:0] ax, logic signed [31:0] ay,
                                             logic signed [31:0] az, logic signed [18:0] ang);
    rotation_t res;
    longint v[3], a[3], k[3], cr[3], r;
    longint sn, cs, dot, sc;
    longint unsigned m, sq, len, q, c;
    int sh;
    v = '{longint'(vx), longint'(vy), longint'(vz)};
    a = '{longint'(ax), longint'(ay), longint'(az)};
    res.w = vw;
    m = 0;
    for (int i = 0; i < 3; i++) if (magnitude(a[i]) > m) m = magnitude(a[i]);
    // Zero axis: pass the vector through and flag it
    if (m == 0) begin
      res.x = vx;
      res.y = vy;
      res.z = vz;
      res.zero = 1'b1;
      return res;
    end
    // Normalize the axis to Q2.30
    sh = 0;
    while ((m << sh) < (64'd1 << 30)) sh++;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      c = magnitude(a[i]) << sh;
      sq = sq + c * c;
    end
    len = floor_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = (((magnitude(a[i]) << sh) << 30) + (len >> 1)) / len;
      k[i] = a[i] < 0 ? -longint'(q) : longint'(q);
    end
    cordic_sin_cos(ang, sn, cs);
    cr[0] = round30(k[1] * v[2] - k[2] * v[1]);
    cr[1] = round30(k[2] * v[0] - k[0] * v[2]);
    cr[2] = round30(k[0] * v[1] - k[1] * v[0]);
    dot = round30(k[0] * v[0] + k[1] * v[1] + k[2] * v[2]);
    sc = round30(dot * (ONE_Q30 - cs));
    for (int i = 0; i < 3; i++) begin
      r = round30(v[i] * cs) + round30(cr[i] * sn) + round30(k[i] * sc);
      r = clip(r, -64'sd2147483648, 64'sd2147483647);
      if (i == 0) res.x = r[31:0];
      else if (i == 1) res.y = r[31:0];
      else res.z = r[31:0];
    end
    res.zero = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
  end

  // Predict on each input transaction, compare on each output transaction
  always @(posedge clk_i) begin
    rotation_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        rot_expected.push_back(rotate_vector(vec_x_i, vec_y_i, vec_z_i, vec_w_i,
                                             axis_x_i, axis_y_i, axis_z_i, angle_i));
      if (out_valid_i && !out_stall_i) begin
        if (rot_expected.size() == 0) begin
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          e = rot_expected.pop_front();
          if (rot_x_i !== e.x) report_mismatch("rot_x", rot_x_i, e.x);
          if (rot_y_i !== e.y) report_mismatch("rot_y", rot_y_i, e.y);
          if (rot_z_i !== e.z) report_mismatch("rot_z", rot_z_i, e.z);
          if (rot_w_i !== e.w) report_mismatch("rot_w", rot_w_i, e.w);
          if (axis_zero_i !== e.zero) report_mismatch("axis_zero", axis_zero_i, e.zero);
        end
      end
    end
    pending_o <= rot_expected.size();
  end

endmodule

// ===== tb/tb_axis_angle_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// tb_axis_angle_vector_rotation: testbench top for the rotation block
// Drives directed corner transactions and then random ones with random
// idling on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_axis_angle_vector_rotation;

  localparam int NUM_RANDOM = 1300;
  localparam int WATCHDOG   = 3000;
  localparam int DRAIN      = 200;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] vec_x, vec_y, vec_z, vec_w, axis_x, axis_y, axis_z;
  logic signed [18:0] angle;
  logic signed [31:0] rot_x, rot_y, rot_z, rot_w;
  logic axis_zero;
  logic calm;
  int errors, pending, quiet_cycles;

  axis_angle_vector_rotation i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z), .vec_w_i(vec_w),
    .axis_x_i(axis_x), .axis_y_i(axis_y), .axis_z_i(axis_z), .angle_i(angle),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .rot_x_o(rot_x), .rot_y_o(rot_y), .rot_z_o(rot_z), .rot_w_o(rot_w),
    .axis_zero_o(axis_zero)
  );

  aavr_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z), .vec_w_i(vec_w),
    .axis_x_i(axis_x), .axis_y_i(axis_y), .axis_z_i(axis_z), .angle_i(angle),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .rot_x_i(rot_x), .rot_y_i(rot_y), .rot_z_i(rot_z), .rot_w_i(rot_w),
    .axis_zero_i(axis_zero),
    .errors_o(errors), .pending_o(pending)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel at random, except in the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 27);
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one transaction, idling cycle by cycle at random first
  task automatic send_rotation(input logic signed [31:0] vx, vy, vz, vw, ax, ay, az,
                               input logic signed [18:0] ang);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    vec_x <= vx; vec_y <= vy; vec_z <= vz; vec_w <= vw;
    axis_x <= ax; axis_y <= ay; axis_z <= az; angle <= ang;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_component();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2:    return $signed($urandom_range(2 * 1048576)) - 1048576;
      3:    return $signed($urandom_range(2 * 65536)) - 65536;
      4:    return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(20)) - 10;
    endcase
  endfunction

  function automatic logic signed [18:0] random_angle();
    if ($urandom_range(9) == 0) return 19'($urandom);
    return 19'($signed($urandom_range(2 * 205887)) - 205887);
  endfunction

  initial begin
    logic signed [31:0] ax, ay, az;
    rst_n = 1'b0;
    calm = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    quiet_cycles = 0;
    {vec_x, vec_y, vec_z, vec_w, axis_x, axis_y, axis_z} = '0;
    angle = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero axis, unit axes, extreme fields, angle limits and beyond
    send_rotation(32'sh10000, 32'sh20000, -32'sh30000, 32'sh5, 0, 0, 0, 19'sd102944);
    send_rotation(32'sh7fffffff, 32'sh80000000, 32'sh1, 32'sh80000000, 0, 0, 0, 0);
    send_rotation(32'sh10000, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 19'sd102944);
    send_rotation(0, 32'sh10000, 0, 0, 32'sh10000, 0, 0, -19'sd102944);
    send_rotation(0, 0, 32'sh10000, 0, 0, 32'sh10000, 0, 19'sd205887);
    send_rotation(32'sh10000, 32'sh10000, 0, 0, 0, 0, 32'sh10000, -19'sd205887);
    send_rotation(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh80000000, 32'sh1, 19'sd262143);
    send_rotation(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, -19'sd262144);
    send_rotation(32'sh7fffffff, 32'sh80000000, 0, -1, 1, 0, 0, 19'sd51472);
    send_rotation(32'sh12345678, -32'sh1234567, 32'sh7654321, 0, 1, 1, 1, 19'sd1);
    send_rotation(32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0, 1, 19'sd51472);
    send_rotation(32'sh10000, 32'sh20000, 32'sh30000, 0, -1, 0, 0, 19'sd102944);
    send_rotation(32'sh10000, 32'sh20000, 32'sh30000, 0, 0, -32'sh10000, 0, 0);
    send_rotation(-1, -1, -1, -1, 32'sh80000000, 0, 0, -19'sd1);
    send_rotation(32'sh40000, -32'sh40000, 32'sh20000, 7, 32'sh3, 32'sh4, 32'sh5,
                  19'sd102943);
    send_rotation(32'sh40000, -32'sh40000, 32'sh20000, 7, 32'sh3, 32'sh4, 32'sh5,
                  -19'sd102945);
    send_rotation(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 19'sd205887);

    // Random: mostly mixed magnitudes, some zero and single-component axes
    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 500 && n < 700);
      ax = random_component();
      ay = random_component();
      az = random_component();
      case ($urandom_range(19))
        0: {ax, ay, az} = '0;
        1: {ay, az} = '0;
        2: {ax, az} = '0;
        3: {ax, ay} = '0;
        default: ;
      endcase
      send_rotation(random_component(), random_component(), random_component(),
                    $urandom, ax, ay, az, random_angle());
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain and settle
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
